>>> src/prd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prd_pkg
// shared widths, register codes and helpers of the pinhole ray generator
// ----------------------------------------------------------------------------
package prd_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int EXTRA_BITS  = 8;
	localparam int MAX_PIXELS  = 4096;

	localparam int CNT_W       = 13;
	localparam int PIX_W       = 12;
	localparam int SIZE_W      = 20;
	localparam int DIR_W       = FRAC_BITS + 2;
	localparam int CFG_IDX_W   = 3;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 56;

	localparam int OFS_W   = PIX_W + 3;
	localparam int MAG_W   = PIX_W + 1;
	localparam int DEN_W   = CNT_W + 1;
	localparam int PROD_W  = MAG_W + SIZE_W;
	localparam int NUM_W   = PROD_W + EXTRA_BITS + 1;
	localparam int AZ_W    = SIZE_W + EXTRA_BITS;
	localparam int NORM_W  = 31;
	localparam int SQ_W    = 2 * NORM_W;
	localparam int SUM_W   = 64;
	localparam int LEN_W   = SUM_W / 2;
	localparam int FNUM_W  = NORM_W + FRAC_BITS + 1;
	localparam int FQUO_W  = FRAC_BITS + 1;

	localparam logic [FQUO_W-1:0] DIR_ONE = FQUO_W'(1) << FRAC_BITS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COLUMNS,
		REG_ROWS,
		REG_PLANE_W,
		REG_PLANE_H,
		REG_PLANE_D
	} cfg_reg_t;

	// pixel count limited to [1, MAX_PIXELS]
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] r;
		r = n;
		if (n == '0) begin
			r = CNT_W'(1);
		end else if (n > CNT_W'(MAX_PIXELS)) begin
			r = CNT_W'(MAX_PIXELS);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/pinhole_ray_direction.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pinhole_ray_direction
// unit direction of the primary camera ray through a pixel center
// ----------------------------------------------------------------------------
//  channel   | direction | word
//  s_axis    | in        | pixel_col [11:0], pixel_row [23:12]
//  m_axis    | out       | dir_x [17:0], dir_y [35:18], dir_z [53:36], zero pad
//  cfg       | in        | cfg_index selects register, cfg_data is the value
//
//  one pixel per clock while the output is not stalled; the pipeline holds
//  the 42 quotient-bit stages of the plane divider, the 32 root stages and
//  the 17 stages of the final divider
//  reset clears the valid bits and loads the default image setup; no sweep
//  a stalled output freezes the whole pipeline, nothing is dropped or doubled
// ----------------------------------------------------------------------------
module pinhole_ray_direction (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [prd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // pixel_col, pixel_row
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [prd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // dir_x, dir_y, dir_z
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [prd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [prd_pkg::SIZE_W-1:0]         cfg_data
);
	import prd_pkg::*;

	// configuration registers
	logic [CNT_W-1:0]  columns_q;
	logic [CNT_W-1:0]  rows_q;
	logic [SIZE_W-1:0] plane_width_q;
	logic [SIZE_W-1:0] plane_height_q;
	logic [SIZE_W-1:0] plane_distance_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q        <= CNT_W'(640);
			rows_q           <= CNT_W'(480);
			plane_width_q    <= SIZE_W'(65536);
			plane_height_q   <= SIZE_W'(49152);
			plane_distance_q <= SIZE_W'(65536);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_COLUMNS: columns_q        <= cfg_data[CNT_W-1:0];
				REG_ROWS:    rows_q           <= cfg_data[CNT_W-1:0];
				REG_PLANE_W: plane_width_q    <= cfg_data;
				REG_PLANE_H: plane_height_q   <= cfg_data;
				REG_PLANE_D: plane_distance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline moves when the output register can take a word
	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: offset from image center, in half pixels
	logic [CNT_W-1:0] w_cnt, h_cnt;
	logic [PIX_W-1:0] col, row;
	logic [OFS_W-1:0] ofs_x, ofs_y;

	assign w_cnt = clamp_count(columns_q);
	assign h_cnt = clamp_count(rows_q);
	assign col   = s_axis_tdata[PIX_W-1:0];
	assign row   = s_axis_tdata[2*PIX_W-1:PIX_W];
	assign ofs_x = OFS_W'({col, 1'b1}) - OFS_W'({w_cnt[CNT_W-1:1], 1'b0});
	assign ofs_y = OFS_W'({row, 1'b1}) - OFS_W'({h_cnt[CNT_W-1:1], 1'b0});

	logic             vld_s1, negx_s1, negy_s1;
	logic [MAG_W-1:0] magx_s1, magy_s1;
	logic [CNT_W-1:0] wx_s1, hy_s1;
	logic [AZ_W-1:0]  az_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			negx_s1 <= ofs_x[OFS_W-1];
			// image rows grow downward, so y flips
			negy_s1 <= !ofs_y[OFS_W-1];
			magx_s1 <= ofs_x[OFS_W-1] ? MAG_W'(-ofs_x) : MAG_W'(ofs_x);
			magy_s1 <= ofs_y[OFS_W-1] ? MAG_W'(-ofs_y) : MAG_W'(ofs_y);
			wx_s1   <= w_cnt;
			hy_s1   <= h_cnt;
			az_s1   <= {plane_distance_q, {EXTRA_BITS{1'b0}}};
		end
	end

	// stage 2: scale by plane size
	logic              vld_s2, negx_s2, negy_s2;
	logic [PROD_W-1:0] prodx_s2, prody_s2;
	logic [CNT_W-1:0]  wx_s2, hy_s2;
	logic [AZ_W-1:0]   az_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			negx_s2  <= negx_s1;
			negy_s2  <= negy_s1;
			prodx_s2 <= PROD_W'(magx_s1) * PROD_W'(plane_width_q);
			prody_s2 <= PROD_W'(magy_s1) * PROD_W'(plane_height_q);
			wx_s2    <= wx_s1;
			hy_s2    <= hy_s1;
			az_s2    <= az_s1;
		end
	end

	// stage 3: extra fraction bits plus half the divisor for rounding
	logic                        vld_s3;
	logic [1:0][NUM_W-1:0]       num_s3;
	logic [1:0][DEN_W-1:0]       den_s3;
	logic [AZ_W+1:0]             pside_s3;   // negx, negy, az

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3[0] <= NUM_W'({prodx_s2, {EXTRA_BITS{1'b0}}}) + NUM_W'(wx_s2);
			num_s3[1] <= NUM_W'({prody_s2, {EXTRA_BITS{1'b0}}}) + NUM_W'(hy_s2);
			den_s3[0] <= {wx_s2, 1'b0};
			den_s3[1] <= {hy_s2, 1'b0};
			pside_s3  <= {negx_s2, negy_s2, az_s2};
		end
	end

	// plane coordinate division by twice the pixel count
	logic                  pdiv_vld;
	logic [1:0][NUM_W-1:0] pdiv_quo;
	logic [AZ_W+1:0]       pdiv_side;

	prd_divpipe #(
		.LANES  (2),
		.NUM_W  (NUM_W),
		.DEN_W  (DEN_W),
		.QUO_W  (NUM_W),
		.SIDE_W (AZ_W + 2)
	) u_plane_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.num       (num_s3),
		.den       (den_s3),
		.in_side   (pside_s3),
		.out_valid (pdiv_vld),
		.quo       (pdiv_quo),
		.out_side  (pdiv_side)
	);

	// shared normalize: largest magnitude into [2^30, 2^31)
	logic [2:0][NUM_W-1:0]  norm_in;
	logic                   norm_vld, norm_zero;
	logic [2:0][NORM_W-1:0] norm_mag;
	logic [1:0]             norm_side;   // negx, negy

	assign norm_in = {NUM_W'(pdiv_side[AZ_W-1:0]), pdiv_quo[1], pdiv_quo[0]};

	prd_norm #(
		.LANES  (3),
		.IN_W   (NUM_W),
		.OUT_W  (NORM_W),
		.SIDE_W (2)
	) u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pdiv_vld),
		.in_mag    (norm_in),
		.in_side   (pdiv_side[AZ_W+1:AZ_W]),
		.out_valid (norm_vld),
		.out_zero  (norm_zero),
		.out_mag   (norm_mag),
		.out_side  (norm_side)
	);

	// stage 4: squares
	logic                   vld_s4, zero_s4;
	logic [1:0]             neg_s4;
	logic [2:0][NORM_W-1:0] mag_s4;
	logic [2:0][SQ_W-1:0]   sq_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= norm_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4 <= norm_zero;
			neg_s4  <= norm_side;
			mag_s4  <= norm_mag;
			for (int l = 0; l < 3; l++) begin
				sq_s4[l] <= SQ_W'(norm_mag[l]) * SQ_W'(norm_mag[l]);
			end
		end
	end

	// stage 5: sum of squares
	logic                   vld_s5;
	logic [SUM_W-1:0]       sum_s5;
	logic [3*NORM_W+2:0]    rside_s5;   // zero, negx, negy, magnitudes

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5   <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
			rside_s5 <= {zero_s4, neg_s4, mag_s4};
		end
	end

	// vector length
	logic                sqrt_vld;
	logic [LEN_W-1:0]    sqrt_len;
	logic [3*NORM_W+2:0] sqrt_side;

	prd_sqrt #(
		.RAD_W  (SUM_W),
		.SIDE_W (3 * NORM_W + 3)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s5),
		.rad       (sum_s5),
		.in_side   (rside_s5),
		.out_valid (sqrt_vld),
		.root      (sqrt_len),
		.out_side  (sqrt_side)
	);

	// stage 6: scaled numerators with rounding half of the length
	logic                   vld_s6;
	logic [2:0][FNUM_W-1:0] fnum_s6;
	logic [2:0][LEN_W-1:0]  len_s6;
	logic [2:0]             fside_s6;   // zero, negx, negy
	logic [2:0][NORM_W-1:0] sqrt_mag;

	assign sqrt_mag = sqrt_side[3*NORM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= sqrt_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fside_s6 <= sqrt_side[3*NORM_W+2:3*NORM_W];
			for (int l = 0; l < 3; l++) begin
				fnum_s6[l] <= FNUM_W'({sqrt_mag[l], {FRAC_BITS{1'b0}}})
					+ FNUM_W'(sqrt_len >> 1);
				len_s6[l]  <= sqrt_len;
			end
		end
	end

	// component / length; no component exceeds the length
	logic                   fdiv_vld;
	logic [2:0][FQUO_W-1:0] fdiv_quo;
	logic [2:0]             fdiv_side;

	prd_divpipe #(
		.LANES  (3),
		.NUM_W  (FNUM_W),
		.DEN_W  (LEN_W),
		.QUO_W  (FQUO_W),
		.SIDE_W (3)
	) u_unit_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.num       (fnum_s6),
		.den       (len_s6),
		.in_side   (fside_s6),
		.out_valid (fdiv_vld),
		.quo       (fdiv_quo),
		.out_side  (fdiv_side)
	);

	// output register: saturate, apply sign, zero vector gives zeros
	logic [2:0][DIR_W-1:0] dir;
	logic [2:0]            dir_neg;

	assign dir_neg = {1'b0, fdiv_side[0], fdiv_side[1]};

	always_comb begin
		logic [FQUO_W-1:0] d;
		for (int l = 0; l < 3; l++) begin
			d = (fdiv_quo[l] > DIR_ONE) ? DIR_ONE : fdiv_quo[l];
			if (fdiv_side[2]) begin
				dir[l] = '0;
			end else if (dir_neg[l]) begin
				dir[l] = -DIR_W'(d);
			end else begin
				dir[l] = DIR_W'(d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= fdiv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= OUT_TDATA_W'({dir[2], dir[1], dir[0]});
		end
	end

endmodule
`default_nettype wire

>>> src/prd_divpipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prd_divpipe
// pipelined restoring divider, one quotient bit per stage, several lanes
// ----------------------------------------------------------------------------
module prd_divpipe #(
	parameter int LANES  = 1,
	parameter int NUM_W  = 8,
	parameter int DEN_W  = 8,
	parameter int QUO_W  = 8,
	parameter int SIDE_W = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [LANES-1:0][NUM_W-1:0]     num,
	input  logic [LANES-1:0][DEN_W-1:0]     den,
	input  logic [SIDE_W-1:0]               in_side,
	output logic                            out_valid,
	output logic [LANES-1:0][QUO_W-1:0]     quo,
	output logic [SIDE_W-1:0]               out_side
);

	// num >> QUO_W must stay below den
	logic                        vld_s  [1:QUO_W];
	logic [LANES-1:0][NUM_W-1:0] num_s  [1:QUO_W];
	logic [LANES-1:0][DEN_W-1:0] den_s  [1:QUO_W];
	logic [LANES-1:0][DEN_W-1:0] rem_s  [1:QUO_W];
	logic [LANES-1:0][QUO_W-1:0] quo_s  [1:QUO_W];
	logic [SIDE_W-1:0]           side_s [1:QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic                        c_vld;
		logic [LANES-1:0][NUM_W-1:0] c_num;
		logic [LANES-1:0][DEN_W-1:0] c_den;
		logic [LANES-1:0][DEN_W-1:0] c_rem;
		logic [LANES-1:0][QUO_W-1:0] c_quo;
		logic [SIDE_W-1:0]           c_side;
		logic [LANES-1:0][DEN_W-1:0] n_rem;
		logic [LANES-1:0][QUO_W-1:0] n_quo;

		if (k == 0) begin : g_first
			always_comb begin
				c_vld  = in_valid;
				c_num  = num;
				c_den  = den;
				c_side = in_side;
				c_quo  = '0;
				for (int l = 0; l < LANES; l++) begin
					c_rem[l] = DEN_W'(num[l] >> QUO_W);
				end
			end
		end else begin : g_next
			always_comb begin
				c_vld  = vld_s[k];
				c_num  = num_s[k];
				c_den  = den_s[k];
				c_side = side_s[k];
				c_quo  = quo_s[k];
				c_rem  = rem_s[k];
			end
		end

		always_comb begin
			logic [DEN_W:0] tmp;
			logic           ge;
			for (int l = 0; l < LANES; l++) begin
				tmp      = {c_rem[l], c_num[l][QUO_W-1-k]};
				ge       = tmp >= {1'b0, c_den[l]};
				n_rem[l] = ge ? DEN_W'(tmp - {1'b0, c_den[l]}) : DEN_W'(tmp);
				n_quo[l] = QUO_W'({c_quo[l], ge});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= c_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[k+1]  <= c_num;
				den_s[k+1]  <= c_den;
				rem_s[k+1]  <= n_rem;
				quo_s[k+1]  <= n_quo;
				side_s[k+1] <= c_side;
			end
		end
	end

	assign out_valid = vld_s[QUO_W];
	assign quo       = quo_s[QUO_W];
	assign out_side  = side_s[QUO_W];

endmodule
`default_nettype wire

>>> src/prd_norm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prd_norm
// common left-justify of several magnitudes, binary shift search per stage
// ----------------------------------------------------------------------------
module prd_norm #(
	parameter int LANES  = 3,
	parameter int IN_W   = 42,
	parameter int OUT_W  = 31,
	parameter int SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [LANES-1:0][IN_W-1:0]  in_mag,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_valid,
	output logic                        out_zero,
	output logic [LANES-1:0][OUT_W-1:0] out_mag,
	output logic [SIDE_W-1:0]           out_side
);

	localparam int NW    = 64;
	localparam int STEPS = $clog2(NW);

	logic                     vld_s  [1:STEPS];
	logic [NW-1:0]            or_s   [1:STEPS];
	logic [LANES-1:0][NW-1:0] lane_s [1:STEPS];
	logic [SIDE_W-1:0]        side_s [1:STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_stage
		localparam int SH = NW >> (k + 1);
		logic                     c_vld;
		logic [NW-1:0]            c_or;
		logic [LANES-1:0][NW-1:0] c_lane;
		logic [SIDE_W-1:0]        c_side;
		logic                     hit;

		if (k == 0) begin : g_first
			always_comb begin
				c_vld  = in_valid;
				c_side = in_side;
				c_or   = '0;
				for (int l = 0; l < LANES; l++) begin
					c_lane[l] = NW'(in_mag[l]);
					c_or      = c_or | NW'(in_mag[l]);
				end
			end
		end else begin : g_next
			always_comb begin
				c_vld  = vld_s[k];
				c_or   = or_s[k];
				c_lane = lane_s[k];
				c_side = side_s[k];
			end
		end

		// top SH bits empty: move everything up by SH
		assign hit = (c_or[NW-1 -: SH] == '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= c_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				or_s[k+1]   <= hit ? (c_or << SH) : c_or;
				side_s[k+1] <= c_side;
				for (int l = 0; l < LANES; l++) begin
					lane_s[k+1][l] <= hit ? (c_lane[l] << SH) : c_lane[l];
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			out_mag[l] = lane_s[STEPS][l][NW-1 -: OUT_W];
		end
	end

	assign out_valid = vld_s[STEPS];
	assign out_zero  = !or_s[STEPS][NW-1];
	assign out_side  = side_s[STEPS];

endmodule
`default_nettype wire

>>> src/prd_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prd_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module prd_sqrt #(
	parameter int RAD_W  = 64,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [RAD_W-1:0]    rad,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	output logic [RAD_W/2-1:0]  root,
	output logic [SIDE_W-1:0]   out_side
);

	localparam int RT  = RAD_W / 2;
	localparam int REM = RT + 2;

	logic              vld_s  [1:RT];
	logic [RAD_W-1:0]  rad_s  [1:RT];
	logic [REM-1:0]    rem_s  [1:RT];
	logic [RT-1:0]     root_s [1:RT];
	logic [SIDE_W-1:0] side_s [1:RT];

	for (genvar k = 0; k < RT; k++) begin : g_stage
		logic              c_vld;
		logic [RAD_W-1:0]  c_rad;
		logic [REM-1:0]    c_rem;
		logic [RT-1:0]     c_root;
		logic [SIDE_W-1:0] c_side;
		logic [REM+1:0]    tmp;
		logic [REM+1:0]    trial;
		logic              ge;

		if (k == 0) begin : g_first
			always_comb begin
				c_vld  = in_valid;
				c_rad  = rad;
				c_rem  = '0;
				c_root = '0;
				c_side = in_side;
			end
		end else begin : g_next
			always_comb begin
				c_vld  = vld_s[k];
				c_rad  = rad_s[k];
				c_rem  = rem_s[k];
				c_root = root_s[k];
				c_side = side_s[k];
			end
		end

		assign tmp   = {c_rem, c_rad[RAD_W-1-2*k -: 2]};
		assign trial = (REM+2)'({c_root, 2'b01});
		assign ge    = tmp >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= c_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= c_rad;
				rem_s[k+1]  <= ge ? REM'(tmp - trial) : REM'(tmp);
				root_s[k+1] <= RT'({c_root, ge});
				side_s[k+1] <= c_side;
			end
		end
	end

	assign out_valid = vld_s[RT];
	assign root      = root_s[RT];
	assign out_side  = side_s[RT];

endmodule
`default_nettype wire

>>> src/prd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prd_checker
// port-level checks of the ray generator, bound to the top level
// ----------------------------------------------------------------------------
module prd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed under stall");

	// input side opens exactly when the output register can move
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready not tied to output slot");

	// z points forward and does not exceed one
	a_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[53]
			&& (!m_axis_tdata[52] || m_axis_tdata[51:36] == 16'd0))
		else $error("dir_z out of range");

	// pad bits stay clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[55:54] == 2'd0)
		else $error("output pad bits set");

	// configuration never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind pinhole_ray_direction prd_checker u_prd_checker (.*);
`default_nettype wire

>>> test/pinhole_ray_direction_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_ray_direction_tb
// self-checking bench: pixels in, predicted unit ray directions compared out
// ----------------------------------------------------------------------------
module pinhole_ray_direction_tb;
	import prd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 130;

	typedef struct packed {
		logic [DIR_W-1:0] dir_z;
		logic [DIR_W-1:0] dir_y;
		logic [DIR_W-1:0] dir_x;
	} ray_dir_t;

	logic                    clk;
	logic                    arst_n;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata;   // pixel_col, pixel_row
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // dir_x, dir_y, dir_z, zero pad
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [SIZE_W-1:0]       cfg_data;

	// predictor copy of the image setup
	logic [CNT_W-1:0]  cam_columns;
	logic [CNT_W-1:0]  cam_rows;
	logic [SIZE_W-1:0] cam_plane_w;
	logic [SIZE_W-1:0] cam_plane_h;
	logic [SIZE_W-1:0] cam_plane_d;

	ray_dir_t pending_rays[$];
	int       mismatch_cnt;
	int       ray_cnt;
	int       idle_cycles;
	bit       rx_stall_enable;

	pinhole_ray_direction i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// plane offset magnitude with 8 extra fraction bits, rounded half up
	function automatic logic [63:0] plane_offset(input logic [PIX_W-1:0] p,
			input logic [CNT_W-1:0] n, input logic [SIZE_W-1:0] sz, output bit neg);
		longint s;
		logic [63:0] mag, den;
		s = 2 * longint'(p) - 2 * longint'(n >> 1) + 1;
		neg = s < 0;
		mag = (s < 0) ? -s : s;
		den = 2 * n;
		return (((mag * sz) << EXTRA_BITS) + den / 2) / den;
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [DIR_W-1:0] unit_component(input logic [63:0] mag,
			input logic [63:0] len, input bit neg);
		logic [63:0] d;
		d = ((mag << FRAC_BITS) + len / 2) / len;
		if (d > (64'd1 << FRAC_BITS)) d = 64'd1 << FRAC_BITS;
		if (neg) d = -d;
		return d[DIR_W-1:0];
	endfunction

	function automatic ray_dir_t predict_ray(input logic [PIX_W-1:0] col,
			input logic [PIX_W-1:0] row);
		ray_dir_t r;
		logic [CNT_W-1:0] w, h;
		logic [63:0] ax, ay, az, m, len;
		bit nx, ypos;
		w = clamp_count(cam_columns);
		h = clamp_count(cam_rows);
		ax = plane_offset(col, w, cam_plane_w, nx);
		ay = plane_offset(row, h, cam_plane_h, ypos);
		az = 64'(cam_plane_d) << EXTRA_BITS;
		m = ax;
		if (ay > m) m = ay;
		if (az > m) m = az;
		r = '0;
		if (m != 0) begin
			while (m >= (64'd1 << 31)) begin
				ax >>= 1; ay >>= 1; az >>= 1; m >>= 1;
			end
			while (m < (64'd1 << 30)) begin
				ax <<= 1; ay <<= 1; az <<= 1; m <<= 1;
			end
			len = root_floor(ax * ax + ay * ay + az * az);
			r.dir_x = unit_component(ax, len, nx);
			// y flips so that up is positive
			r.dir_y = unit_component(ay, len, !ypos && ay != 0);
			r.dir_z = unit_component(az, len, 1'b0);
		end
		return r;
	endfunction

	// valid stays up after the accept; the next call drops it or sends its own pixel, the drain drops it
	task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] row);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {row, col};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_rays.push_back(predict_ray(col, row));
	endtask

	// valid stays up after the accept; set_camera drops it after the last write
	task automatic write_reg(input cfg_reg_t idx, input logic [SIZE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_COLUMNS: cam_columns = value[CNT_W-1:0];
			REG_ROWS:    cam_rows    = value[CNT_W-1:0];
			REG_PLANE_W: cam_plane_w = value;
			REG_PLANE_H: cam_plane_h = value;
			REG_PLANE_D: cam_plane_d = value;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_rays.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_camera(input logic [CNT_W-1:0] cols, input logic [CNT_W-1:0] rws,
			input logic [SIZE_W-1:0] pw, input logic [SIZE_W-1:0] ph,
			input logic [SIZE_W-1:0] pd);
		wait_drained();
		write_reg(REG_COLUMNS, SIZE_W'(cols));
		write_reg(REG_ROWS, SIZE_W'(rws));
		write_reg(REG_PLANE_W, pw);
		write_reg(REG_PLANE_H, ph);
		write_reg(REG_PLANE_D, pd);
		cfg_valid <= 1'b0;
	endtask

	// corners, center and out-of-image pixels at the default setup
	task automatic test_default_corners();
		send_pixel(0, 0);
		send_pixel(639, 479);
		send_pixel(320, 240);
		send_pixel(319, 239);
		send_pixel(4095, 4095);
		send_pixel(12'hAAA, 12'h555);
		send_pixel(12'h555, 12'hAAA);
	endtask

	// zero and oversized counts clamp, extreme plane sizes
	task automatic test_extremes();
		set_camera(0, 8191, 20'hFFFFF, 1, 1);
		send_pixel(0, 0);
		send_pixel(4095, 0);
		send_pixel(0, 4095);
		set_camera(4096, 1, 1, 20'hFFFFF, 20'hFFFFF);
		send_pixel(0, 0);
		send_pixel(2048, 0);
		send_pixel(4095, 4095);
		set_camera(1, 1, 20'hFFFFF, 20'hFFFFF, 1);
		send_pixel(0, 0);
		send_pixel(1, 1);
		set_camera(5000, 2, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		send_pixel(0, 1);
		send_pixel(4095, 4095);
	endtask

	// random setups with mostly in-image pixels, some anywhere
	task automatic test_random_frames();
		for (int phase = 0; phase < 12; phase++) begin
			set_camera(CNT_W'($urandom_range(0, 8191) % (phase < 3 ? 8192 : 4097)),
				CNT_W'($urandom_range(0, 4200)), SIZE_W'($urandom_range(1, 20'hFFFFF)),
				SIZE_W'($urandom_range(1, 20'hFFFFF)),
				SIZE_W'($urandom_range(1, 20'hFFFFF)));
			rx_stall_enable = (phase % 3) != 2;
			for (int k = 0; k < 90; k++) begin
				if ($urandom_range(0, 4) == 0)
					send_pixel(PIX_W'($urandom), PIX_W'($urandom));
				else
					send_pixel(PIX_W'($urandom_range(0, clamp_count(cam_columns) - 1)),
						PIX_W'($urandom_range(0, clamp_count(cam_rows) - 1)));
			end
		end
		rx_stall_enable = 1'b1;
	endtask

	// receiver side: random stall per word while stalls are enabled, then compare
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_stall_enable ? $urandom_range(0, 5) : 0;
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			check_word(m_axis_tdata);
		end
	end

	task automatic check_word(input logic [OUT_TDATA_W-1:0] word);
		ray_dir_t got, want;
		got = word[3*DIR_W-1:0];
		ray_cnt++;
		if (pending_rays.size() == 0) begin
			mismatch_cnt++;
			if (mismatch_cnt <= 10)
				$display("unexpected word %h", word);
		end else begin
			want = pending_rays.pop_front();
			if (got !== want) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("ray mismatch: expected x=%h y=%h z=%h got x=%h y=%h z=%h",
						want.dir_x, want.dir_y, want.dir_z,
						got.dir_x, got.dir_y, got.dir_z);
			end
		end
	endtask

	// watchdog on cycles with no accepted word on any channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_COLUMNS;
		cfg_data      = '0;
		idle_cycles   = 0;
		mismatch_cnt  = 0;
		ray_cnt       = 0;
		rx_stall_enable = 1'b1;
		cam_columns = 640;
		cam_rows    = 480;
		cam_plane_w = 65536;
		cam_plane_h = 49152;
		cam_plane_d = 65536;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_corners();
		test_extremes();
		test_random_frames();
		wait_drained();
		$display("checked %0d ray directions over directed corners and 12 random setups",
			ray_cnt);
		if (mismatch_cnt == 0 && pending_rays.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
